// File: rtl/core/slir_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slir_pkg: shared types and constants for the sorted insertion list
// Word widths, status codes and the command that is broadcast to every cell.
// ----------------------------------------------------------------------------
package slir_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned COUNT_W      = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } slir_status_e;

  typedef struct packed {
    logic                        ins;
    logic                        rem;
    logic signed [VALUE_W-1:0]   value;
  } slir_cmd_t;

endpackage : slir_pkg
`default_nettype wire

// File: rtl/core/sorted_list_insert_remove.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_insert_remove: bounded ascending list of signed values
// Input word: mode_i (0 insert, 1 remove first equal) and value_i, taken when
// in_valid_i is high and in_stall_o is low. Output word: status_o, count_o
// and smallest_o, taken when out_valid_o is high and out_stall_i is low.
// Each operation gives exactly one output word, in the cycle after acceptance.
// Throughput is one word per cycle unless the output stalls: a row of CAPACITY
// cells compares every entry against the broadcast value and shifts one place.
// The only wide net is the OR of the per-cell match flags on remove.
// An insert into a full list is refused with status 2; a remove of an absent
// value returns status 1; neither changes the list.
// When the output word is stalled the input stalls too; the word holds.
// Reset empties the list (count 0) and drops any pending output word.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove #(
  parameter int unsigned CAPACITY = slir_pkg::CAPACITY_DEF
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire                                     mode_i,
  input  wire  signed [slir_pkg::VALUE_W-1:0]     value_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic        [1:0]                       status_o,
  output logic        [slir_pkg::COUNT_W-1:0]     count_o,
  output logic signed [slir_pkg::VALUE_W-1:0]     smallest_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  logic                           accept;
  logic                           full;
  logic                           found;
  logic [CNT_W-1:0]               occ_q;
  logic [CNT_W-1:0]               occ_d;
  slir_pkg::slir_cmd_t            cmd;
  slir_pkg::slir_status_e         status_d;
  slir_pkg::slir_status_e         status_q;
  logic                           out_valid_q;
  logic signed [slir_pkg::VALUE_W-1:0] smallest_d;
  logic signed [slir_pkg::VALUE_W-1:0] smallest_q;

  logic [CAPACITY-1:0]            occ;
  logic [CAPACITY-1:0]            ge;
  logic [CAPACITY-1:0]            eq;
  logic signed [slir_pkg::VALUE_W-1:0] entry      [CAPACITY];
  logic signed [slir_pkg::VALUE_W-1:0] entry_next [CAPACITY];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (occ_q == CNT_W'(CAPACITY));
  assign found      = |eq;

  assign cmd.ins   = accept && (mode_i == slir_pkg::MODE_INSERT) && !full;
  assign cmd.rem   = accept && (mode_i == slir_pkg::MODE_REMOVE);
  assign cmd.value = value_i;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                                prev_ge;
    logic signed [slir_pkg::VALUE_W-1:0] prev_entry;
    logic signed [slir_pkg::VALUE_W-1:0] next_entry;

    assign occ[i] = (occ_q > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_ge    = 1'b0;
      assign prev_entry = '0;
    end else begin : g_body
      assign prev_ge    = ge[i-1];
      assign prev_entry = entry[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_entry = '0;
    end else begin : g_link
      assign next_entry = entry[i+1];
    end

    slir_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .occ_i        (occ[i]),
      .found_i      (found),
      .prev_ge_i    (prev_ge),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .ge_o         (ge[i]),
      .eq_o         (eq[i]),
      .entry_o      (entry[i]),
      .entry_next_o (entry_next[i])
    );
  end

  always_comb begin
    occ_d    = occ_q;
    status_d = slir_pkg::ST_DONE;
    if (mode_i == slir_pkg::MODE_INSERT) begin
      if (full) begin
        status_d = slir_pkg::ST_FULL;
      end else begin
        occ_d = occ_q + CNT_W'(1);
      end
    end else begin
      if (found) begin
        occ_d = occ_q - CNT_W'(1);
      end else begin
        status_d = slir_pkg::ST_NOT_FOUND;
      end
    end
    smallest_d = (occ_d == '0) ? '0 : entry_next[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        occ_q       <= occ_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      smallest_q <= smallest_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign count_o     = slir_pkg::COUNT_W'(occ_q);
  assign smallest_o  = smallest_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (status_q == slir_pkg::ST_FULL) |-> full)
    else $error("full status with list not full");

  a_empty_smallest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (occ_q == '0) |-> (smallest_q == '0))
    else $error("empty list reports nonzero smallest");

  a_insert_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> (occ_q == $past(occ_q) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_missing_keeps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rem && !found |=> (occ_q == $past(occ_q)))
    else $error("failed remove changed occupancy");

endmodule : sorted_list_insert_remove
`default_nettype wire

// File: rtl/core/slir_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slir_cell: one entry of the sorted list
// Holds one value, compares it against the broadcast word and takes its own
// next value from itself, the broadcast word or a neighbor.
// ----------------------------------------------------------------------------
module slir_cell (
  input  wire                                     clk_i,
  input  wire  slir_pkg::slir_cmd_t               cmd_i,
  input  wire                                     occ_i,
  input  wire                                     found_i,
  input  wire                                     prev_ge_i,
  input  wire  signed [slir_pkg::VALUE_W-1:0]     prev_entry_i,
  input  wire  signed [slir_pkg::VALUE_W-1:0]     next_entry_i,
  output logic                                    ge_o,
  output logic                                    eq_o,
  output logic signed [slir_pkg::VALUE_W-1:0]     entry_o,
  output logic signed [slir_pkg::VALUE_W-1:0]     entry_next_o
);

  logic signed [slir_pkg::VALUE_W-1:0] entry_q;
  logic signed [slir_pkg::VALUE_W-1:0] entry_d;
  logic                                ge_val;

  assign ge_val = (entry_q >= cmd_i.value);
  assign ge_o   = !occ_i || ge_val;
  assign eq_o   = occ_i && (entry_q == cmd_i.value);

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.ins) begin
      if (prev_ge_i) begin
        entry_d = prev_entry_i;
      end else if (ge_o) begin
        entry_d = cmd_i.value;
      end
    end else if (cmd_i.rem && found_i && occ_i && ge_val) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o      = entry_q;
  assign entry_next_o = entry_d;

endmodule : slir_cell
`default_nettype wire

// File: tb/sv/sorted_list_insert_remove_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_test: self-checking bench for the sorted list
// A driver feeds insert and remove words from a queue with random gaps and
// drain pauses. A shadow list predicts status, count and smallest entry for
// every accepted word. A monitor stalls the output at random and checks each
// result word against the oldest prediction.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_test;

  localparam int unsigned CAP         = slir_pkg::CAPACITY_DEF;
  localparam int unsigned RAND_OPS    = 1850;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic                                mode;
    logic signed [slir_pkg::VALUE_W-1:0] value;
    int unsigned                         gap;
    bit                                  drain;
  } op_t;

  typedef struct {
    slir_pkg::slir_status_e              status;
    logic [slir_pkg::COUNT_W-1:0]        count;
    logic signed [slir_pkg::VALUE_W-1:0] smallest;
  } outcome_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                in_valid_i = 1'b0;
  logic                                mode_i = slir_pkg::MODE_INSERT;
  logic signed [slir_pkg::VALUE_W-1:0] value_i = '0;
  logic                                out_stall_i = 1'b0;
  logic                                in_stall_o;
  logic                                out_valid_o;
  logic [1:0]                          status_o;
  logic [slir_pkg::COUNT_W-1:0]        count_o;
  logic signed [slir_pkg::VALUE_W-1:0] smallest_o;

  op_t                                 op_q[$];
  outcome_t                            outcome_q[$];
  logic signed [slir_pkg::VALUE_W-1:0] held[CAP];
  int unsigned                         held_n = 0;
  logic signed [slir_pkg::VALUE_W-1:0] pool[16];
  int unsigned                         total_n = 0;
  int unsigned                         sent_n = 0;
  int unsigned                         got_n = 0;
  int unsigned                         err_n = 0;
  int unsigned                         cycle_n = 0;

  sorted_list_insert_remove u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .count_o     (count_o),
    .smallest_o  (smallest_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic list_apply(input logic mode,
                            input logic signed [slir_pkg::VALUE_W-1:0] v);
    outcome_t    o;
    int unsigned pos;
    o.status = slir_pkg::ST_DONE;
    pos = 0;
    if (mode == slir_pkg::MODE_INSERT) begin
      if (held_n >= CAP) begin
        o.status = slir_pkg::ST_FULL;
      end else begin
        while (pos < held_n && held[pos] < v) pos++;
        for (int unsigned i = held_n; i > pos; i--) held[i] = held[i-1];
        held[pos] = v;
        held_n++;
      end
    end else begin
      while (pos < held_n && held[pos] != v) pos++;
      if (pos >= held_n) begin
        o.status = slir_pkg::ST_NOT_FOUND;
      end else begin
        for (int unsigned i = pos; i + 1 < held_n; i++) held[i] = held[i+1];
        held_n--;
      end
    end
    o.count    = slir_pkg::COUNT_W'(held_n);
    o.smallest = (held_n > 0) ? held[0] : '0;
    outcome_q.push_back(o);
  endtask

  function automatic int unsigned pick_gap(input int unsigned style);
    if (style == 0) return 0;
    if (style == 1) return $urandom_range(0, 18);
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 18) : 0;
  endfunction

  task automatic add_op(input logic mode,
                        input logic signed [slir_pkg::VALUE_W-1:0] v,
                        input int unsigned gap, input bit drain);
    op_t o;
    o.mode  = mode;
    o.value = v;
    o.gap   = gap;
    o.drain = drain;
    op_q.push_back(o);
    total_n++;
  endtask

  // Driver: hold a stalled word, else wait out the gap (and a drain) and load.
  always @(posedge clk_i or negedge rst_ni) begin : drive_p
    bit          took;
    op_t         nxt;
    int unsigned gap_n;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i     <= slir_pkg::MODE_INSERT;
      value_i    <= '0;
      sent_n     <= 0;
      gap_n = 0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) list_apply(mode_i, value_i);
      if (in_valid_i && !took) begin
        in_valid_i <= 1'b1;
      end else if (op_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (gap_n < op_q[0].gap) begin
        gap_n++;
        in_valid_i <= 1'b0;
      end else if (op_q[0].drain && (sent_n + took) != got_n) begin
        in_valid_i <= 1'b0;
      end else begin
        nxt = op_q.pop_front();
        gap_n = 0;
        in_valid_i <= 1'b1;
        mode_i     <= nxt.mode;
        value_i    <= nxt.value;
      end
      if (took) sent_n <= sent_n + 1;
    end
  end

  // Monitor: check each taken result word, then draw the next stall.
  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    outcome_t    exp_w;
    int unsigned stall_left;
    bit          calm;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      got_n       <= 0;
      stall_left = 0;
      calm = 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got_n <= got_n + 1;
        if (outcome_q.size() == 0) begin
          $error("unexpected result word: status %0d count %0d smallest %0d",
                 status_o, count_o, smallest_o);
          err_n++;
        end else begin
          exp_w = outcome_q.pop_front();
          if (status_o !== exp_w.status) begin
            $error("status: expected %0d, actual %0d", exp_w.status, status_o);
            err_n++;
          end
          if (count_o !== exp_w.count) begin
            $error("count: expected %0d, actual %0d", exp_w.count, count_o);
            err_n++;
          end
          if (smallest_o !== exp_w.smallest) begin
            $error("smallest: expected %0d, actual %0d", exp_w.smallest, smallest_o);
            err_n++;
          end
        end
        if ($urandom_range(0, 63) == 0) calm = !calm;
        stall_left = calm ? 0 : ($urandom_range(0, 1) ? $urandom_range(0, 18) : 0);
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : stim_p
    int unsigned                         style;
    int unsigned                         ins_pct;
    int unsigned                         phase_len;
    int unsigned                         made;
    logic signed [slir_pkg::VALUE_W-1:0] v;

    pool[0] = 32'sh8000_0000;
    pool[1] = 32'sh7fff_ffff;
    pool[2] = 32'sh0000_0000;
    pool[3] = -32'sd1;
    pool[4] = 32'sd1;
    pool[5] = 32'sh5555_5555;
    pool[6] = 32'shaaaa_aaaa;
    for (int i = 7; i < 16; i++) begin
      pool[i] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40);
    end

    // Directed: empty remove, lone entry, extremes, duplicates, full, tail.
    style = 1;
    add_op(slir_pkg::MODE_REMOVE, 32'sd5, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_INSERT, 32'sd0, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_REMOVE, 32'sd0, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_INSERT, 32'sh7fff_ffff, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_INSERT, 32'sh8000_0000, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_INSERT, -32'sd1, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_INSERT, 32'sd1, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_INSERT, 32'sh8000_0000, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_REMOVE, 32'sh8000_0000, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_REMOVE, 32'sd12345, pick_gap(style), 1'b0);
    for (int i = 0; i < 12; i++) begin
      v = (i < 2) ? pool[5 + i] : $urandom;
      add_op(slir_pkg::MODE_INSERT, v, pick_gap(style), 1'b0);
    end
    add_op(slir_pkg::MODE_INSERT, 32'sd7, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_REMOVE, 32'sh7fff_ffff, pick_gap(style), 1'b0);
    add_op(slir_pkg::MODE_INSERT, 32'sh7fff_ffff, pick_gap(style), 1'b0);

    // Random phases: fill, drain or mixed, each opening with a drain pause.
    made = 0;
    while (made < RAND_OPS) begin
      style     = $urandom_range(0, 2);
      phase_len = $urandom_range(40, 200);
      case ($urandom_range(0, 2))
        0:       ins_pct = 80;
        1:       ins_pct = 20;
        default: ins_pct = 50;
      endcase
      for (int unsigned k = 0; k < phase_len && made < RAND_OPS; k++) begin
        v = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 15)] : $urandom;
        add_op(($urandom_range(0, 99) < ins_pct) ? slir_pkg::MODE_INSERT
                                                 : slir_pkg::MODE_REMOVE,
               v, pick_gap(style), k == 0);
        made++;
      end
    end

    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (got_n != total_n) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      $error("results still expected at end: %0d", outcome_q.size());
      err_n++;
    end
    if (err_n == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/slir_pkg.sv
rtl/core/slir_cell.sv
rtl/core/sorted_list_insert_remove.sv
tb/sv/sorted_list_insert_remove_test.sv
